>>> rtl/core/srmp_pkg.sv
// ----------------------------------------------------------------------------
// srmp_pkg
// Shared constants, codes and types of the stepper ramp controller.
// ----------------------------------------------------------------------------
package srmp_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int COUNT_WIDTH = 16;

	localparam int ADDR_W     = $clog2(TABLE_DEPTH);
	localparam int RELOAD_W   = 22;
	localparam int SPEED_W    = 8;
	localparam int STEP_W     = 16;
	localparam int IDLE_W     = 16;
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 16;
	localparam int PINS_W     = 4;
	localparam int PHASE_W    = 3;
	localparam int MODE_W     = 2;
	localparam int REM_W      = COUNT_WIDTH + 2;
	localparam int DIVISOR_W  = ADDR_W + 2;
	localparam int DIVIDEND_W = RELOAD_W + 1;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

	localparam logic [RELOAD_W-1:0] PERIOD_T0 = 22'd2236068;
	localparam logic [RELOAD_W-1:0] PERIOD_T1 = 22'd926179;

	localparam logic [SPEED_W-1:0] MAX_SPEED_RST    = 8'd200;
	localparam logic [IDLE_W-1:0]  IDLE_TIMEOUT_RST = 16'd300;
	localparam logic [PINS_W-1:0]  PINS_RST         = 4'd15;

	localparam logic [MODE_W-1:0] MODE_START = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STEP  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

	localparam logic [CFG_ADDR_W-1:0] REG_MAX_SPEED    = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_IDLE_TIMEOUT = 1'd1;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} tbl_rd_t;

	typedef struct packed {
		logic [PINS_W-1:0]  pins;
		logic               running;
		logic [SPEED_W-1:0] speed;
		logic               use_tbl;
	} s1_item_t;

	typedef struct packed {
		logic [SPEED_W-1:0]  speed;
		logic                running;
		logic [RELOAD_W-1:0] reload;
		logic [PINS_W-1:0]   pins;
	} result_t;

	function automatic logic [PINS_W-1:0] phase_to_pins(input logic [PHASE_W-1:0] ph);
		logic [PINS_W-1:0] p;
		unique case (ph)
			3'd0: p = 4'd15;
			3'd1: p = 4'd3;
			3'd2: p = 4'd11;
			3'd3: p = 4'd8;
			3'd4: p = 4'd10;
			3'd5: p = 4'd2;
			3'd6: p = 4'd14;
			3'd7: p = 4'd12;
		endcase
		return p;
	endfunction

endpackage

>>> rtl/core/srmp_div.sv
// ----------------------------------------------------------------------------
// srmp_div
// Restoring divider, one quotient bit per cycle, for the period table build.
// ----------------------------------------------------------------------------
module srmp_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [srmp_pkg::DIVIDEND_W-1:0]    dividend,
	input  logic [srmp_pkg::DIVISOR_W-1:0]     divisor,
	output logic                               done,
	output logic [srmp_pkg::DIVIDEND_W-1:0]    quotient
);

	logic                               busy_q;
	logic                               done_q;
	logic [srmp_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [srmp_pkg::DIVIDEND_W-1:0]    dvd_q;
	logic [srmp_pkg::DIVISOR_W-1:0]     rem_q;
	logic [srmp_pkg::DIVISOR_W-1:0]     dsr_q;
	logic [srmp_pkg::DIVISOR_W:0]       trial;
	logic [srmp_pkg::DIVISOR_W:0]       diff;
	logic                               fits;

	assign trial = {rem_q, dvd_q[srmp_pkg::DIVIDEND_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == srmp_pkg::DIV_CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= srmp_pkg::DIV_CNT_W'(srmp_pkg::DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - srmp_pkg::DIV_CNT_W'(1);
				if (cnt_q == srmp_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[srmp_pkg::DIVISOR_W-1:0] : trial[srmp_pkg::DIVISOR_W-1:0];
			dvd_q <= {dvd_q[srmp_pkg::DIVIDEND_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

>>> rtl/core/srmp_table.sv
// ----------------------------------------------------------------------------
// srmp_table
// Period table memory and the sequencer that builds it after reset.
// ----------------------------------------------------------------------------
module srmp_table (
	input  logic                             clk,
	input  logic                             arst_n,
	input  srmp_pkg::tbl_rd_t                rd,
	output logic [srmp_pkg::RELOAD_W-1:0]    rd_data,
	output logic                             ready
);

	localparam logic [2:0] BLD_SEED0 = 3'd0;
	localparam logic [2:0] BLD_SEED1 = 3'd1;
	localparam logic [2:0] BLD_DIV   = 3'd2;
	localparam logic [2:0] BLD_DONE  = 3'd3;

	logic [2:0]                          state_q;
	logic [srmp_pkg::ADDR_W-1:0]         n_q;
	logic [srmp_pkg::RELOAD_W-1:0]       prev_q;
	logic [srmp_pkg::RELOAD_W-1:0]       mem_q [srmp_pkg::TABLE_DEPTH];
	logic [srmp_pkg::RELOAD_W-1:0]       rd_data_q;

	logic                                we;
	logic [srmp_pkg::ADDR_W-1:0]         wa;
	logic [srmp_pkg::RELOAD_W-1:0]       wd;
	logic [srmp_pkg::RELOAD_W-1:0]       next_val;
	logic                                div_start;
	logic                                div_done;
	logic [srmp_pkg::DIVIDEND_W-1:0]     div_dvd;
	logic [srmp_pkg::DIVISOR_W-1:0]      div_dsr;
	logic [srmp_pkg::DIVIDEND_W-1:0]     div_q;
	logic                                last_entry;

	assign next_val   = prev_q - srmp_pkg::RELOAD_W'(div_q);
	assign last_entry = n_q == srmp_pkg::ADDR_W'(srmp_pkg::TABLE_DEPTH - 1);

	always_comb begin
		we        = 1'b0;
		wa        = n_q;
		wd        = next_val;
		div_start = 1'b0;
		div_dvd   = {next_val, 1'b0};
		div_dsr   = {n_q + srmp_pkg::ADDR_W'(1), 2'b01};
		unique case (state_q)
			BLD_SEED0: begin
				we = 1'b1;
				wa = '0;
				wd = srmp_pkg::PERIOD_T0;
			end
			BLD_SEED1: begin
				we        = 1'b1;
				wa        = srmp_pkg::ADDR_W'(1);
				wd        = srmp_pkg::PERIOD_T1;
				div_start = srmp_pkg::TABLE_DEPTH > 2;
				div_dvd   = {srmp_pkg::PERIOD_T1, 1'b0};
				div_dsr   = {srmp_pkg::ADDR_W'(2), 2'b01};
			end
			BLD_DIV: begin
				we        = div_done;
				div_start = div_done && !last_entry;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BLD_SEED0;
			n_q     <= '0;
			prev_q  <= '0;
		end else begin
			unique case (state_q)
				BLD_SEED0: state_q <= BLD_SEED1;
				BLD_SEED1: begin
					prev_q  <= srmp_pkg::PERIOD_T1;
					n_q     <= srmp_pkg::ADDR_W'(2);
					state_q <= (srmp_pkg::TABLE_DEPTH > 2) ? BLD_DIV : BLD_DONE;
				end
				BLD_DIV: begin
					if (div_done) begin
						prev_q <= next_val;
						if (last_entry) begin
							state_q <= BLD_DONE;
						end else begin
							n_q <= n_q + srmp_pkg::ADDR_W'(1);
						end
					end
				end
				BLD_DONE: state_q <= BLD_DONE;
				default:  state_q <= BLD_SEED0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		if (rd.en) begin
			rd_data_q <= mem_q[rd.addr];
		end
	end

	srmp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_q)
	);

	assign rd_data = rd_data_q;
	assign ready   = state_q == BLD_DONE;

endmodule

>>> rtl/core/srmp_ctrl.sv
// ----------------------------------------------------------------------------
// srmp_ctrl
// Move state, ramp update, table lookup stage and result register.
// ----------------------------------------------------------------------------
module srmp_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [srmp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [srmp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [srmp_pkg::MODE_W-1:0]         mode,
	input  logic [srmp_pkg::STEP_W-1:0]         step_count,
	input  logic                                direction,
	output logic                                out_valid,
	input  logic                                out_ready,
	output srmp_pkg::result_t                   result,
	output srmp_pkg::tbl_rd_t                   tbl_rd,
	input  logic [srmp_pkg::RELOAD_W-1:0]       tbl_data,
	input  logic                                tbl_ready
);

	logic [srmp_pkg::SPEED_W-1:0]       max_speed_q;
	logic [srmp_pkg::IDLE_W-1:0]        timeout_q;
	logic                               run_q;
	logic                               dir_q;
	logic [srmp_pkg::COUNT_WIDTH-1:0]   target_q;
	logic [srmp_pkg::COUNT_WIDTH-1:0]   done_q;
	logic [srmp_pkg::SPEED_W-1:0]       speed_q;
	logic [srmp_pkg::PHASE_W-1:0]       phase_q;
	logic [srmp_pkg::PINS_W-1:0]        pins_q;
	logic [srmp_pkg::RELOAD_W-1:0]      reload_q;
	logic [srmp_pkg::IDLE_W-1:0]        idle_q;

	logic                               s1_v;
	srmp_pkg::s1_item_t                 item_s1;
	logic                               out_v;
	srmp_pkg::result_t                  out_q;

	logic                               run_n;
	logic                               dir_n;
	logic [srmp_pkg::COUNT_WIDTH-1:0]   target_n;
	logic [srmp_pkg::COUNT_WIDTH-1:0]   done_n;
	logic [srmp_pkg::COUNT_WIDTH-1:0]   done_inc;
	logic [srmp_pkg::SPEED_W-1:0]       speed_n;
	logic [srmp_pkg::SPEED_W-1:0]       spd_ramp;
	logic [srmp_pkg::SPEED_W-1:0]       spd_dec;
	logic [srmp_pkg::PHASE_W-1:0]       phase_n;
	logic [srmp_pkg::PINS_W-1:0]        pins_n;
	logic [srmp_pkg::IDLE_W-1:0]        idle_n;
	logic signed [srmp_pkg::REM_W-1:0]  rem_s;
	logic signed [srmp_pkg::REM_W-1:0]  spd_s;
	logic                               use_tbl;
	logic [srmp_pkg::ADDR_W-1:0]        rd_addr;
	logic                               acc;
	logic                               s1_go;

	assign s1_go    = s1_v && (!out_v || out_ready);
	assign in_ready = tbl_ready && (!s1_v || s1_go);
	assign acc      = in_valid && in_ready;

	assign done_inc = done_q + srmp_pkg::COUNT_WIDTH'(1);
	assign spd_dec  = (speed_q == '0) ? '0 : speed_q - srmp_pkg::SPEED_W'(1);
	assign rem_s    = srmp_pkg::REM_W'(target_q) - srmp_pkg::REM_W'(done_q);
	assign spd_s    = srmp_pkg::REM_W'(speed_q);

	always_comb begin
		run_n    = run_q;
		dir_n    = dir_q;
		target_n = target_q;
		done_n   = done_q;
		speed_n  = speed_q;
		phase_n  = phase_q;
		pins_n   = pins_q;
		idle_n   = idle_q;
		use_tbl  = 1'b0;
		spd_ramp = spd_dec;
		rd_addr  = '0;
		unique case (mode)
			srmp_pkg::MODE_START: begin
				target_n = srmp_pkg::COUNT_WIDTH'(step_count);
				dir_n    = direction;
				run_n    = 1'b1;
			end
			srmp_pkg::MODE_STEP: begin
				if (!run_q) begin
					target_n = '0;
					done_n   = '0;
					speed_n  = '0;
				end else begin
					phase_n = dir_q ? phase_q - srmp_pkg::PHASE_W'(1)
					                : phase_q + srmp_pkg::PHASE_W'(1);
					pins_n  = srmp_pkg::phase_to_pins(phase_n);
					if (rem_s <= spd_s) begin
						spd_ramp = spd_dec;
					end else if (speed_q < max_speed_q) begin
						spd_ramp = speed_q + srmp_pkg::SPEED_W'(1);
					end else begin
						spd_ramp = spd_dec;
					end
					if (int'(spd_ramp) > srmp_pkg::TABLE_DEPTH - 1) begin
						rd_addr = srmp_pkg::ADDR_W'(srmp_pkg::TABLE_DEPTH - 1);
					end else begin
						rd_addr = srmp_pkg::ADDR_W'(spd_ramp);
					end
					use_tbl = 1'b1;
					if (done_inc >= target_q) begin
						run_n    = 1'b0;
						target_n = '0;
						done_n   = '0;
						speed_n  = '0;
					end else begin
						done_n  = done_inc;
						speed_n = spd_ramp;
					end
				end
			end
			srmp_pkg::MODE_TICK: begin
				if (!run_q) begin
					if (idle_q != '1) begin
						idle_n = idle_q + srmp_pkg::IDLE_W'(1);
					end
				end else begin
					idle_n = '0;
				end
				if (idle_n >= timeout_q) begin
					pins_n = '0;
				end
			end
			default: ;
		endcase
	end

	assign tbl_rd.en   = acc && use_tbl;
	assign tbl_rd.addr = rd_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= srmp_pkg::MAX_SPEED_RST;
			timeout_q   <= srmp_pkg::IDLE_TIMEOUT_RST;
			run_q       <= 1'b0;
			dir_q       <= 1'b0;
			target_q    <= '0;
			done_q      <= '0;
			speed_q     <= '0;
			phase_q     <= '0;
			pins_q      <= srmp_pkg::PINS_RST;
			reload_q    <= srmp_pkg::PERIOD_T0;
			idle_q      <= '0;
			s1_v        <= 1'b0;
			out_v       <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					srmp_pkg::REG_MAX_SPEED:    max_speed_q <= cfg_wdata[srmp_pkg::SPEED_W-1:0];
					srmp_pkg::REG_IDLE_TIMEOUT: timeout_q   <= cfg_wdata;
				endcase
			end
			if (acc) begin
				run_q    <= run_n;
				dir_q    <= dir_n;
				target_q <= target_n;
				done_q   <= done_n;
				speed_q  <= speed_n;
				phase_q  <= phase_n;
				pins_q   <= pins_n;
				idle_q   <= idle_n;
			end
			if (s1_go && item_s1.use_tbl) begin
				reload_q <= tbl_data;
			end
			if (acc) begin
				s1_v <= 1'b1;
			end else if (s1_go) begin
				s1_v <= 1'b0;
			end
			if (s1_go) begin
				out_v <= 1'b1;
			end else if (out_ready) begin
				out_v <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1.pins    <= pins_n;
			item_s1.running <= run_n;
			item_s1.speed   <= speed_n;
			item_s1.use_tbl <= use_tbl;
		end
		if (s1_go) begin
			out_q.pins    <= item_s1.pins;
			out_q.running <= item_s1.running;
			out_q.speed   <= item_s1.speed;
			out_q.reload  <= item_s1.use_tbl ? tbl_data : reload_q;
		end
	end

	assign out_valid = out_v;
	assign result    = out_q;

`ifndef SYNTHESIS
	a_stopped_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!run_q |-> (speed_q == '0 && done_q == '0))
		else $error("stopped with nonzero speed or step count");

	a_reload_load: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && item_s1.use_tbl |=> reload_q == $past(tbl_data))
		else $error("reload not taken from table");

	a_phase_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		acc && mode == srmp_pkg::MODE_STEP && run_q && !dir_q
		|=> phase_q == srmp_pkg::PHASE_W'($past(phase_q) + srmp_pkg::PHASE_W'(1)))
		else $error("forward step did not advance phase");
`endif

endmodule

>>> rtl/core/stepper_ramp_controller.sv
// ----------------------------------------------------------------------------
// stepper_ramp_controller
// Half-step stepper controller with trapezoidal speed ramp and idle release.
//
// Channel  Dir  Handshake          Payload
// s_*      in   tvalid/tready      tuser: mode; tdata: step_count, direction
// m_*      out  tvalid/tready      tdata: phase_pins, timer_reload, running, speed_now
// cfg_*    in   cfg_we             cfg_addr: register index; cfg_wdata: value
//
// One word accepted per cycle when the m side does not stall; each result is
// registered in the lookup stage and then in the result register. The period
// table lives in a synchronous memory with a registered read, read once per step.
// After reset a bit-serial divider builds the table; s_tready stays low meanwhile.
// A stalled m side holds the result register and then the lookup stage.
// ----------------------------------------------------------------------------
module stepper_ramp_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [15:0] step_count, [16] direction
	input  logic [1:0]  s_tuser,   // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [3:0] phase_pins, [25:4] timer_reload,
	                               // [26] running, [34:27] speed_now
	input  logic        cfg_we,
	input  logic [0:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);

	srmp_pkg::tbl_rd_t                   tbl_rd;
	logic [srmp_pkg::RELOAD_W-1:0]       tbl_data;
	logic                                tbl_ready;
	srmp_pkg::result_t                   result;

	srmp_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (tbl_rd),
		.rd_data (tbl_data),
		.ready   (tbl_ready)
	);

	srmp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.mode       (s_tuser),
		.step_count (s_tdata[15:0]),
		.direction  (s_tdata[16]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.result     (result),
		.tbl_rd     (tbl_rd),
		.tbl_data   (tbl_data),
		.tbl_ready  (tbl_ready)
	);

	assign m_tdata = {5'b0, result};

endmodule

>>> dv/stepper_ramp_controller_tb.sv
// ----------------------------------------------------------------------------
// stepper_ramp_controller_tb
// Self-checking bench for the half-step stepper ramp controller. A driver
// feeds start, step-expiry, millisecond-tick and unused-mode words from a
// queue. A behavioral predictor tracks phase, ramp speed, period table and
// idle timer, and a monitor checks every result word field by field. The
// run covers a directed opening and then randomized moves under several
// register settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module stepper_ramp_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [srmp_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam int unsigned STALL_LIMIT = 20000;
	localparam logic [srmp_pkg::PINS_W-1:0] COIL_PATTERN [8] = '{
		4'd15, 4'd3, 4'd11, 4'd8, 4'd10, 4'd2, 4'd14, 4'd12
	};

	typedef struct {
		logic [srmp_pkg::MODE_W-1:0] mode;
		logic [srmp_pkg::STEP_W-1:0] cnt;
		logic                        dir;
	} motor_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // [15:0] step_count, [16] direction
	logic [1:0]  s_tuser = '0;   // [1:0] mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // [3:0] phase_pins, [25:4] timer_reload,
	                             // [26] running, [34:27] speed_now
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_addr = '0;
	logic [15:0] cfg_wdata = '0;

	stepper_ramp_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	motor_cmd_t          cmd_q [$];
	srmp_pkg::result_t   motion_q [$];

	int unsigned src_idle_pct = 33;
	int unsigned snk_idle_pct = 66;
	int unsigned words_queued = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;
	int unsigned n_start = 0, n_step = 0, n_tick = 0, n_spare = 0, n_writes = 0;
	int unsigned quiet_cycles = 0;

	logic [srmp_pkg::RELOAD_W-1:0] ramp_period [srmp_pkg::TABLE_DEPTH];
	logic [srmp_pkg::SPEED_W-1:0]  top_speed = srmp_pkg::MAX_SPEED_RST;
	logic [srmp_pkg::IDLE_W-1:0]   idle_limit = srmp_pkg::IDLE_TIMEOUT_RST;
	logic                          moving = 1'b0;
	logic                          mv_dir = 1'b0;
	logic [srmp_pkg::STEP_W-1:0]   tgt_steps = '0;
	logic [srmp_pkg::STEP_W-1:0]   done_steps = '0;
	logic [srmp_pkg::SPEED_W-1:0]  spd_idx = '0;
	logic [srmp_pkg::PHASE_W-1:0]  phase = '0;
	logic [srmp_pkg::PINS_W-1:0]   coils = srmp_pkg::PINS_RST;
	logic [srmp_pkg::RELOAD_W-1:0] reload = srmp_pkg::PERIOD_T0;
	logic [srmp_pkg::IDLE_W-1:0]   idle_cnt = '0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void build_periods();
		int unsigned prev;
		ramp_period[0] = srmp_pkg::PERIOD_T0;
		ramp_period[1] = srmp_pkg::PERIOD_T1;
		for (int n = 2; n < srmp_pkg::TABLE_DEPTH; n++) begin
			prev = 32'(ramp_period[n-1]);
			ramp_period[n] = srmp_pkg::RELOAD_W'(prev - (2 * prev) / 32'(4 * n + 1));
		end
	endfunction

	task automatic clear_move();
		tgt_steps = '0;
		done_steps = '0;
		spd_idx = '0;
	endtask

	task automatic predict_word(input motor_cmd_t cmd);
		srmp_pkg::result_t r;
		int rem;
		int spd;
		int lut;
		case (cmd.mode)
			srmp_pkg::MODE_START: begin
				tgt_steps = cmd.cnt;
				mv_dir = cmd.dir;
				moving = 1'b1;
				n_start++;
			end
			srmp_pkg::MODE_STEP: begin
				n_step++;
				if (!moving) begin
					clear_move();
				end else begin
					phase = mv_dir ? phase - 3'd1 : phase + 3'd1;
					coils = COIL_PATTERN[phase];
					rem = int'(tgt_steps) - int'(done_steps);
					spd = int'(spd_idx);
					if (rem <= spd)
						spd--;
					else if (spd < int'(top_speed))
						spd++;
					else
						spd--;
					if (spd < 0)
						spd = 0;
					spd_idx = spd[srmp_pkg::SPEED_W-1:0];
					lut = (int'(spd_idx) > srmp_pkg::TABLE_DEPTH - 1) ?
						srmp_pkg::TABLE_DEPTH - 1 : int'(spd_idx);
					reload = ramp_period[lut];
					done_steps = done_steps + 1'b1;
					if (done_steps >= tgt_steps) begin
						moving = 1'b0;
						clear_move();
					end
				end
			end
			srmp_pkg::MODE_TICK: begin
				n_tick++;
				if (!moving) begin
					if (idle_cnt != '1)
						idle_cnt = idle_cnt + 1'b1;
				end else begin
					idle_cnt = '0;
				end
				if (idle_cnt >= idle_limit)
					coils = '0;
			end
			default: begin
				n_spare++;
			end
		endcase
		r.pins = coils;
		r.reload = reload;
		r.running = moving;
		r.speed = spd_idx;
		motion_q.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [39:0] got,
			input logic [39:0] want);
		if (mismatches < 50)
			$display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
		mismatches++;
	endtask

	// drive words
	always @(posedge clk or negedge arst_n) begin
		motor_cmd_t cmd;
		logic show;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			show = s_tvalid;
			if (s_tvalid && s_tready) begin
				cmd = cmd_q.pop_front();
				predict_word(cmd);
				show = 1'b0;
			end
			if (!show && cmd_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
				show = 1'b1;
			s_tvalid <= show;
			if (show) begin
				s_tdata <= {7'd0, cmd_q[0].dir, cmd_q[0].cnt};
				s_tuser <= cmd_q[0].mode;
			end
		end
	end

	// check results
	always @(posedge clk or negedge arst_n) begin
		srmp_pkg::result_t got;
		srmp_pkg::result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[34:0];
				results_seen++;
				if (motion_q.size() == 0) begin
					report_mismatch("result with nothing pending", m_tdata, '0);
				end else begin
					want = motion_q.pop_front();
					if (got.pins !== want.pins)
						report_mismatch("phase_pins", 40'(got.pins), 40'(want.pins));
					if (got.reload !== want.reload)
						report_mismatch("timer_reload", 40'(got.reload), 40'(want.reload));
					if (got.running !== want.running)
						report_mismatch("running", 40'(got.running), 40'(want.running));
					if (got.speed !== want.speed)
						report_mismatch("speed_now", 40'(got.speed), 40'(want.speed));
				end
			end
			m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
				$display("stepper_ramp_controller_tb: FAIL");
				$finish;
			end
		end
	end

	task automatic push_cmd(input logic [srmp_pkg::MODE_W-1:0] mode,
			input logic [srmp_pkg::STEP_W-1:0] cnt, input logic dir);
		motor_cmd_t c;
		c.mode = mode;
		c.cnt = cnt;
		c.dir = dir;
		cmd_q.push_back(c);
		words_queued++;
	endtask

	task automatic push_noise(input logic [srmp_pkg::MODE_W-1:0] mode);
		push_cmd(mode, srmp_pkg::STEP_W'($urandom_range(0, 16'hFFFF)),
			1'($urandom_range(0, 1)));
	endtask

	task automatic wait_drained();
		while (cmd_q.size() != 0 || motion_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == srmp_pkg::REG_MAX_SPEED)
			top_speed = val[srmp_pkg::SPEED_W-1:0];
		else
			idle_limit = val;
		n_writes++;
		@(negedge clk);
	endtask

	task automatic queue_random_traffic(input int unsigned n_words);
		int unsigned base;
		int unsigned pick;
		int unsigned cnt;
		int unsigned n_steps;
		int unsigned burst;
		base = words_queued;
		while (words_queued - base < n_words) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				pick = $urandom_range(0, 99);
				if (pick < 55)
					cnt = $urandom_range(0, 20);
				else if (pick < 80)
					cnt = $urandom_range(21, 300);
				else if (pick < 95)
					cnt = $urandom_range(0, 16'hFFFF);
				else
					cnt = 0;
				push_cmd(srmp_pkg::MODE_START, srmp_pkg::STEP_W'(cnt),
					1'($urandom_range(0, 1)));
				n_steps = (cnt <= 300) ? cnt + $urandom_range(0, 2) : $urandom_range(1, 40);
				for (int i = 0; i < n_steps; i++) begin
					pick = $urandom_range(0, 99);
					if (pick < 6)
						push_noise(srmp_pkg::MODE_TICK);
					else if (pick < 8)
						push_cmd(srmp_pkg::MODE_START,
							srmp_pkg::STEP_W'($urandom_range(0, cnt)),
							1'($urandom_range(0, 1)));
					push_noise(srmp_pkg::MODE_STEP);
				end
				pick = $urandom_range(0, 99);
				burst = 0;
				if (pick < 30)
					burst = $urandom_range(0, 12);
				else if (pick < 40)
					burst = (idle_limit < 400) ? idle_limit + 2 : 12;
				repeat (burst) push_noise(srmp_pkg::MODE_TICK);
			end else if (pick < 85) begin
				push_noise(srmp_pkg::MODE_TICK);
			end else if (pick < 93) begin
				push_noise(srmp_pkg::MODE_STEP);
			end else begin
				push_noise(MODE_SPARE);
			end
		end
	endtask

	initial begin
		build_periods();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_cmd(srmp_pkg::MODE_STEP, 16'h0000, 1'b0);
		push_cmd(srmp_pkg::MODE_TICK, 16'hFFFF, 1'b1);
		push_cmd(MODE_SPARE, 16'hFFFF, 1'b1);
		push_cmd(srmp_pkg::MODE_START, 16'd3, 1'b0);
		repeat (4) push_cmd(srmp_pkg::MODE_STEP, 16'h0000, 1'b0);
		push_cmd(srmp_pkg::MODE_START, 16'd0, 1'b0);
		push_cmd(srmp_pkg::MODE_STEP, 16'h0000, 1'b0);
		push_cmd(srmp_pkg::MODE_START, 16'd10, 1'b1);
		repeat (3) push_cmd(srmp_pkg::MODE_STEP, 16'hFFFF, 1'b1);
		push_cmd(srmp_pkg::MODE_TICK, 16'h0000, 1'b0);
		push_cmd(srmp_pkg::MODE_START, 16'd2, 1'b1);
		repeat (2) push_cmd(srmp_pkg::MODE_STEP, 16'h0000, 1'b0);
		push_cmd(srmp_pkg::MODE_START, 16'hFFFF, 1'b1);
		repeat (2) push_cmd(srmp_pkg::MODE_STEP, 16'h0000, 1'b0);
		push_cmd(srmp_pkg::MODE_START, 16'd1, 1'b0);
		push_cmd(srmp_pkg::MODE_STEP, 16'h0000, 1'b0);
		push_cmd(MODE_SPARE, 16'h0000, 1'b0);
		wait_drained();

		write_reg(srmp_pkg::REG_MAX_SPEED, 16'd0);
		write_reg(srmp_pkg::REG_IDLE_TIMEOUT, 16'd0);
		queue_random_traffic(150);
		wait_drained();

		write_reg(srmp_pkg::REG_MAX_SPEED, 16'd255);
		write_reg(srmp_pkg::REG_IDLE_TIMEOUT, 16'hFFFF);
		push_cmd(srmp_pkg::MODE_START, 16'd520, 1'b0);
		repeat (520) push_noise(srmp_pkg::MODE_STEP);
		queue_random_traffic(100);
		wait_drained();

		src_idle_pct = 66;
		snk_idle_pct = 33;
		write_reg(srmp_pkg::REG_MAX_SPEED, 16'd1);
		write_reg(srmp_pkg::REG_IDLE_TIMEOUT, 16'd1);
		queue_random_traffic(100);
		// hold the sender until every result is back
		wait_drained();
		queue_random_traffic(100);
		wait_drained();

		write_reg(srmp_pkg::REG_MAX_SPEED, 16'($urandom_range(0, 255)));
		write_reg(srmp_pkg::REG_IDLE_TIMEOUT, 16'($urandom_range(2, 30)));
		queue_random_traffic(150);
		wait_drained();

		src_idle_pct = 0;
		snk_idle_pct = 0;
		write_reg(srmp_pkg::REG_MAX_SPEED, 16'd200);
		write_reg(srmp_pkg::REG_IDLE_TIMEOUT, 16'd300);
		push_cmd(srmp_pkg::MODE_START, 16'd0, 1'b0);
		push_cmd(srmp_pkg::MODE_STEP, 16'h0000, 1'b0);
		queue_random_traffic(150);
		wait_drained();

		$display("covered %0d starts, %0d step expiries, %0d ms ticks, %0d unused-mode words",
			n_start, n_step, n_tick, n_spare);
		$display("%0d results checked over %0d register writes, %0d mismatches",
			results_seen, n_writes, mismatches);
		if (mismatches == 0)
			$display("stepper_ramp_controller_tb: PASS");
		else
			$display("stepper_ramp_controller_tb: FAIL");
		$finish;
	end

endmodule
